[design/bis_pkg.sv]
package bis_pkg;

    localparam int SET_BITS_DEF = 1024;
    localparam int BUCKET_BITS  = 8;
    localparam int OP_W         = 3;
    localparam int VALUE_W      = 10;
    localparam int INDEX_W      = 7;
    localparam int HIGH_W       = 11;
    localparam int MAX_BUCKETS  = 1 << INDEX_W;
    localparam int VALUE_LIMIT  = (1 << VALUE_W) - 1;

    // Width of one slice of the nonzero-bucket flags examined per scan step.
    localparam int GROUP        = 32;
    localparam int GROUP_W      = 5;

    localparam logic [VALUE_W-1:0] MAX_VALUE_RST = 10'd1023;

    localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST      = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
    localparam logic [OP_W-1:0] OP_INTERSECT = 3'd4;
    localparam logic [OP_W-1:0] OP_UNION     = 3'd5;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_MODIFY,
        ST_SCAN,
        ST_FINISH
    } bis_state_t;

    // Index of the highest set bit of a group of flags; zero when none is set.
    function automatic logic [GROUP_W-1:0] top_of_group(input logic [GROUP-1:0] flags);
        logic [GROUP_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < GROUP; i++)
        begin
            if (flags[i])
            begin
                pos = GROUP_W'(i);
            end
        end
        return pos;
    endfunction

    // Index of the highest set bit of one bucket; zero when the bucket is empty.
    function automatic logic [2:0] top_of_bucket(input logic [BUCKET_BITS-1:0] bits);
        logic [2:0] pos;
        pos = '0;
        for (int i = 0; i < BUCKET_BITS; i++)
        begin
            if (bits[i])
            begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

[design/bis_if.sv]
interface bis_item_if;
    logic                          valid;
    logic                          ready;
    logic [bis_pkg::OP_W-1:0]      operation;
    logic [bis_pkg::VALUE_W-1:0]   value;
    logic [bis_pkg::INDEX_W-1:0]   bucket_index;
    logic [bis_pkg::BUCKET_BITS-1:0] other_byte;

    modport source (output valid, operation, value, bucket_index, other_byte, input ready);
    modport sink   (input valid, operation, value, bucket_index, other_byte, output ready);
endinterface

interface bis_result_if;
    logic                               valid;
    logic                               ready;
    logic                               status;
    logic                               is_member;
    logic                               is_empty;
    logic signed [bis_pkg::HIGH_W-1:0]  highest_member;

    modport source (output valid, status, is_member, is_empty, highest_member, input ready);
    modport sink   (input valid, status, is_member, is_empty, highest_member, output ready);
endinterface

[design/bitmap_integer_set.sv]
// Set of integers 0..max_value held as a bitmap of byte buckets in a single-port memory, with
// one flip-flop per bucket marking it written since the last clear and one marking it nonzero.
// An item is taken only while the sequencer is idle; a result is delivered through an output
// register, so the next item may be taken while a result beat still waits. Between acceptance and
// the next acceptance an item goes through the bucket read, the modify and write-back, a priority
// scan that walks down the nonzero-bucket flags 32 buckets per step until it finds the highest
// nonzero bucket (at most ceil(buckets/32) steps, four with the default size), and a final step
// that fetches that bucket and encodes the highest member. That final step repeats for as long
// as the output register still holds an earlier result beat that has not been taken. Clearing,
// and writing max_value, empty the set at once by clearing the flags. max_value is at byte
// address 0 of the APB port.
module bitmap_integer_set #(
    parameter int SET_BITS = bis_pkg::SET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    bis_item_if.sink     item,
    bis_result_if.source result
);

    localparam int BB           = bis_pkg::BUCKET_BITS;
    localparam int VW           = bis_pkg::VALUE_W;
    localparam int HW           = bis_pkg::HIGH_W;
    localparam int GRP          = bis_pkg::GROUP;
    localparam int FULL_BUCKETS = (SET_BITS + BB - 1) / BB;
    localparam int STORE_DEPTH  = (FULL_BUCKETS < bis_pkg::MAX_BUCKETS) ?
                                  FULL_BUCKETS : bis_pkg::MAX_BUCKETS;
    localparam int BA_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int GROUPS       = (STORE_DEPTH + GRP - 1) / GRP;
    localparam int GW           = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int LIMIT        = (SET_BITS - 1 < bis_pkg::VALUE_LIMIT) ?
                                  SET_BITS - 1 : bis_pkg::VALUE_LIMIT;
    localparam logic [VW-1:0] LIMIT_V = VW'(LIMIT);

    bis_pkg::bis_state_t state_reg, state_next;

    logic [VW-1:0]                  max_value_reg;
    logic [bis_pkg::OP_W-1:0]       op_reg;
    logic [VW-1:0]                  value_reg;
    logic [bis_pkg::INDEX_W-1:0]    index_reg;
    logic [BB-1:0]                  other_reg;
    logic                           status_reg;
    logic                           member_reg;
    logic [GW-1:0]                  grp_reg;
    logic                           found_reg;
    logic [BA_W-1:0]                top_bucket_reg;

    logic [BB-1:0]                  mem [STORE_DEPTH];
    logic [BB-1:0]                  rd_raw_reg;
    logic                           rd_ok_reg;
    logic [STORE_DEPTH-1:0]         valid_reg;
    logic [STORE_DEPTH-1:0]         nz_reg;

    logic                           out_valid_reg;
    logic                           out_status_reg;
    logic                           out_member_reg;
    logic                           out_empty_reg;
    logic [HW-1:0]                  out_high_reg;

    logic                           cfg_write;
    logic                           accept;
    logic                           out_free;
    logic [VW-1:0]                  emax;
    logic [BA_W-1:0]                in_addr;
    logic [BA_W-1:0]                item_addr;
    logic [BB-1:0]                  cur_byte;
    logic [VW-1:0]                  base;
    logic [BB-1:0]                  span_mask;
    logic [BB-1:0]                  bit_sel;
    logic                           oor;
    logic                           is_hit;
    logic                           do_write;
    logic                           do_clear;
    logic [BB-1:0]                  new_byte;

    logic [GROUPS*GRP-1:0]          nz_pad;
    logic [GRP-1:0]                 slice;
    logic                           slice_hit;
    logic [bis_pkg::GROUP_W-1:0]    slice_top;
    logic [BA_W-1:0]                found_bucket;

    logic                           rd_en;
    logic [BA_W-1:0]                rd_addr;
    logic                           wr_en;
    logic                           clear_all;
    logic                           load_out;
    logic [HW-1:0]                  high_value;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? 32'(max_value_reg) : 32'd0;

    assign item.ready = (state_reg == bis_pkg::ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    assign emax = (max_value_reg < LIMIT_V) ? max_value_reg : LIMIT_V;

    assign in_addr   = (item.operation == bis_pkg::OP_INTERSECT ||
                        item.operation == bis_pkg::OP_UNION) ?
                       BA_W'(item.bucket_index) : BA_W'(item.value[VW-1:3]);
    assign item_addr = (op_reg == bis_pkg::OP_INTERSECT || op_reg == bis_pkg::OP_UNION) ?
                       BA_W'(index_reg) : BA_W'(value_reg[VW-1:3]);

    // A bucket not written since the last clear reads as empty.
    assign cur_byte = rd_ok_reg ? rd_raw_reg : '0;
    assign base     = {index_reg, 3'b000};
    assign bit_sel  = BB'(1) << value_reg[2:0];

    always_comb
    begin
        for (int k = 0; k < BB; k++)
        begin
            span_mask[k] = ((VW + 1)'(base) + (VW + 1)'(k)) <= (VW + 1)'(emax);
        end
    end

    // Bucket update for the captured item.
    always_comb
    begin
        oor      = 1'b0;
        is_hit   = 1'b0;
        do_write = 1'b0;
        do_clear = 1'b0;
        new_byte = cur_byte;
        case (op_reg)
            bis_pkg::OP_ADD:
            begin
                oor      = value_reg > emax;
                do_write = !oor;
                new_byte = cur_byte | bit_sel;
            end
            bis_pkg::OP_REMOVE:
            begin
                oor      = value_reg > emax;
                do_write = !oor;
                new_byte = cur_byte & ~bit_sel;
            end
            bis_pkg::OP_TEST:
            begin
                oor    = value_reg > emax;
                is_hit = !oor && ((cur_byte & bit_sel) != '0);
            end
            bis_pkg::OP_CLEAR:
            begin
                do_clear = 1'b1;
            end
            bis_pkg::OP_INTERSECT:
            begin
                oor      = base > emax;
                do_write = !oor;
                new_byte = cur_byte & (other_reg & span_mask);
            end
            bis_pkg::OP_UNION:
            begin
                oor      = base > emax;
                do_write = !oor;
                new_byte = cur_byte | (other_reg & span_mask);
            end
            default:
            begin
                oor = 1'b0;
            end
        endcase
    end

    // Priority scan over one group of nonzero-bucket flags per cycle, from the top down.
    assign nz_pad       = (GROUPS * GRP)'(nz_reg);
    assign slice        = nz_pad[grp_reg * GRP +: GRP];
    assign slice_hit    = (slice != '0);
    assign slice_top    = bis_pkg::top_of_group(slice);
    assign found_bucket = BA_W'(32'(grp_reg) * GRP + 32'(slice_top));

    assign high_value = found_reg ? HW'({top_bucket_reg, bis_pkg::top_of_bucket(cur_byte)})
                                  : '1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bis_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bis_pkg::ST_MODIFY;
                end
            end
            bis_pkg::ST_MODIFY:
            begin
                state_next = bis_pkg::ST_SCAN;
            end
            bis_pkg::ST_SCAN:
            begin
                if (slice_hit || grp_reg == '0)
                begin
                    state_next = bis_pkg::ST_FINISH;
                end
            end
            bis_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = bis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bis_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer strobes.
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = in_addr;
        wr_en     = 1'b0;
        clear_all = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            bis_pkg::ST_IDLE:
            begin
                rd_en = accept;
            end
            bis_pkg::ST_MODIFY:
            begin
                wr_en     = do_write;
                clear_all = do_clear;
            end
            bis_pkg::ST_SCAN:
            begin
                rd_en   = slice_hit;
                rd_addr = found_bucket;
            end
            bis_pkg::ST_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bis_pkg::ST_IDLE;
            max_value_reg <= bis_pkg::MAX_VALUE_RST;
            valid_reg     <= '0;
            nz_reg        <= '0;
            out_valid_reg <= 1'b0;
            grp_reg       <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                max_value_reg <= pwdata[VW-1:0];
            end
            if (cfg_write || clear_all)
            begin
                valid_reg <= '0;
                nz_reg    <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[item_addr] <= 1'b1;
                nz_reg[item_addr]    <= (new_byte != '0);
            end
            if (state_reg == bis_pkg::ST_MODIFY)
            begin
                grp_reg <= GW'(GROUPS - 1);
            end
            else if (state_reg == bis_pkg::ST_SCAN)
            begin
                found_reg <= slice_hit;
                if (!slice_hit && grp_reg != '0)
                begin
                    grp_reg <= grp_reg - GW'(1);
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload, bucket memory and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= item.operation;
            value_reg <= item.value;
            index_reg <= item.bucket_index;
            other_reg <= item.other_byte;
        end
        if (state_reg == bis_pkg::ST_MODIFY)
        begin
            status_reg <= oor;
            member_reg <= is_hit;
        end
        if (state_reg == bis_pkg::ST_SCAN && slice_hit)
        begin
            top_bucket_reg <= found_bucket;
        end
        if (wr_en)
        begin
            mem[item_addr] <= new_byte;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
            rd_ok_reg  <= valid_reg[rd_addr];
        end
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_member_reg <= member_reg;
            out_empty_reg  <= !found_reg;
            out_high_reg   <= high_value;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = out_status_reg;
    assign result.is_member      = out_member_reg;
    assign result.is_empty       = out_empty_reg;
    assign result.highest_member = $signed(out_high_reg);

endmodule

[design/bis_checker.sv]
module bis_props (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic        result_status,
    input logic        result_member,
    input logic        result_empty,
    input logic [10:0] result_high
);

    // A beat on the result channel stays offered until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat withdrawn before it was taken");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(result_status) && $stable(result_member) &&
            $stable(result_empty) && $stable(result_high))
        else $error("result payload changed while stalled");

    // The empty flag and the highest member must agree.
    a_empty_high: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_empty == (result_high == 11'h7FF)))
        else $error("is_empty disagrees with highest_member");

    // A member found implies a successful test on a set that is not empty.
    a_member_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_member |-> !result_status && !result_empty)
        else $error("membership reported with error or on an empty set");

    // The sequencer works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input ready again straight after a beat");

endmodule

bind bitmap_integer_set bis_props u_bis_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_status (result.status),
    .result_member (result.is_member),
    .result_empty  (result.is_empty),
    .result_high   (result.highest_member)
);
